### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker module of the range allocator.
// Each macro expands to one labeled concurrent assertion, reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold in the cycle where ante holds.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range allocator check failed");

// Next-cycle implication: cons must hold in the cycle after the one where ante holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range allocator check failed");

`endif

### hw/rtl/ffra_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the first-fit range allocator.
// No dependencies; imported by every module of the block.
package ffra_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int MAX_RANGES_DEF = 64;
    localparam int LINE_BYTES_DEF = 64;

    // Region size after reset and the tail absorb limit
    localparam logic [31:0] REGION_RESET = 32'd67108864;
    localparam logic [31:0] TAIL_LIMIT   = 32'(4 << 10);

    // Request function codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // One free range as stored in the range memory
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
    } t_range;

    // One result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_offset;
        logic [31:0] granted_bytes;
        logic [31:0] payload_bytes;
        logic [6:0]  range_count;
        logic        region_empty;
        logic [31:0] used_bytes;
    } t_result;

endpackage

### hw/rtl/ffra_round.sv
`timescale 1ns / 1ps
// Line-size rounding unit: remainder by LINE_BYTES through a reciprocal multiply,
// three pipeline stages. Depends on ffra_pkg.
module ffra_round #(
    parameter int LINE_BYTES = ffra_pkg::LINE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value,
    output logic        o_done,
    output logic [31:0] o_aligned,
    output logic        o_ok
);
    import ffra_pkg::*;

    localparam int RW    = $clog2(LINE_BYTES + 1);
    localparam int SHIFT = 32 + $clog2(LINE_BYTES);
    localparam int PW    = SHIFT + 32;
    // ceil(2^SHIFT / LINE_BYTES): 33-bit reciprocal, exact quotient for any 32-bit value
    localparam logic [63:0] RECIP    = ((64'd1 << SHIFT) + 64'(LINE_BYTES) - 64'd1)
                                       / 64'(LINE_BYTES);
    localparam logic [31:0] RECIP_LO = RECIP[31:0];
    localparam logic        RECIP_HI = RECIP[32];
    localparam logic [31:0] LB_32    = 32'(LINE_BYTES);

    logic [2:0]    r_pipe;
    logic          r_done;
    logic [31:0]   r_val;
    logic [63:0]   r_prod;
    logic [31:0]   r_quot;
    logic [RW-1:0] r_rem;

    logic [PW-1:0] s_prod_full;
    logic [31:0]   s_rem_full;
    logic [32:0]   s_pad;
    logic [32:0]   s_sum;

    // Full product: low 32 reciprocal bits plus the top reciprocal bit as a shift
    assign s_prod_full = PW'(r_prod) + (RECIP_HI ? PW'({r_val, 32'd0}) : {PW{1'b0}});
    assign s_rem_full  = r_val - (r_quot * LB_32);

    // Control: stage valid bits and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe <= '0;
            r_done <= 1'b0;
        end else begin
            r_pipe <= {r_pipe[1:0], i_start};
            r_done <= r_pipe[2];
        end
    end

    // Datapath: product, quotient, remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_pipe[0]) begin
            r_prod <= 64'(r_val) * 64'(RECIP_LO);
        end
        if (r_pipe[1]) begin
            r_quot <= s_prod_full[PW-1 -: 32];
        end
        if (r_pipe[2]) begin
            r_rem <= s_rem_full[RW-1:0];
        end
    end

    // Round up by the missing part of the last line; carry out means overflow
    assign s_pad     = (r_rem == '0) ? 33'd0 : (33'(LINE_BYTES) - 33'(r_rem));
    assign s_sum     = {1'b0, r_val} + s_pad;
    assign o_aligned = s_sum[31:0];
    assign o_ok      = (r_val != 32'd0) && !s_sum[32];
    assign o_done    = r_done;

endmodule

### hw/rtl/ffra_mem.sv
`timescale 1ns / 1ps
// Range table memory: one write port, one read port with registered data.
// Depends on ffra_pkg for the entry type.
module ffra_mem #(
    parameter int DEPTH = ffra_pkg::MAX_RANGES_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  ffra_pkg::t_range i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output ffra_pkg::t_range o_rd_data
);
    import ffra_pkg::*;

    t_range mem [DEPTH];
    t_range r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/ffra_ctrl.sv
`timescale 1ns / 1ps
// Allocator sequencer: streams the range table through a read-modify-write
// compaction pass. Depends on ffra_pkg; drives ffra_mem and ffra_round.
module ffra_ctrl #(
    parameter int MAX_RANGES = ffra_pkg::MAX_RANGES_DEF,
    localparam int AW        = $clog2(MAX_RANGES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request
    input  logic              start,
    output logic              busy,
    input  logic              i_func,
    input  logic [31:0]       i_req_bytes,
    input  logic [31:0]       i_free_offset,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [31:0]       i_cfg_data,
    // rounding unit
    output logic              o_rnd_start,
    input  logic              i_rnd_done,
    input  logic [31:0]       i_rnd_aligned,
    input  logic              i_rnd_ok,
    // range memory
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output ffra_pkg::t_range  o_wr_data,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  ffra_pkg::t_range  i_rd_data,
    // result
    output logic              o_res_valid,
    output ffra_pkg::t_result o_res
);
    import ffra_pkg::*;

    localparam int CW = $clog2(MAX_RANGES + 1);

    localparam logic [1:0] S_INIT  = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_ROUND = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    // control state
    logic [1:0]    r_state,   n_state;
    logic [CW-1:0] r_live,    n_live;
    logic [CW-1:0] r_rd,      n_rd;
    logic [CW-1:0] r_wr,      n_wr;
    logic          r_vld,     n_vld;
    logic          r_found,   n_found;
    logic          r_res_valid, n_res_valid;
    logic [31:0]   r_used,    n_used;
    logic [31:0]   r_region,  n_region;
    logic [31:0]   r_len0,    n_len0;
    // payload
    logic          r_func,    n_func;
    logic [31:0]   r_req,     n_req;
    logic [31:0]   r_off,     n_off;
    logic [31:0]   r_sz,      n_sz;
    logic [31:0]   r_a,       n_a;
    logic [31:0]   r_boff,    n_boff;
    logic [31:0]   r_granted, n_granted;
    t_result       r_res,     n_res;

    logic          s_keep;
    t_range        s_kept;
    logic [31:0]   s_end;
    logic [31:0]   s_eend;
    logic [31:0]   s_rest;
    logic [32:0]   s_add;
    logic [31:0]   s_used_add;
    logic [31:0]   s_used_sub;
    logic          s_cfg_fire;

    assign s_cfg_fire = i_cfg_valid && o_cfg_ready;

    // Per-entry arithmetic on the entry coming out of the memory
    assign s_end  = r_off + r_sz;
    assign s_eend = i_rd_data.start + i_rd_data.length;
    assign s_rest = i_rd_data.length - r_a;

    // Saturating usage updates
    assign s_add      = {1'b0, r_used} + {1'b0, r_a};
    assign s_used_add = s_add[32] ? 32'hFFFF_FFFF : s_add[31:0];
    assign s_used_sub = (r_used < r_req) ? 32'd0 : (r_used - r_req);

    // Sequencer. Reads run ahead of writes (write index never passes the read
    // index), so a written entry is never read again within the same pass.
    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_vld       = r_vld;
        n_found     = r_found;
        n_res_valid = 1'b0;
        n_used      = r_used;
        n_region    = r_region;
        n_len0      = r_len0;
        n_func      = r_func;
        n_req       = r_req;
        n_off       = r_off;
        n_sz        = r_sz;
        n_a         = r_a;
        n_boff      = r_boff;
        n_granted   = r_granted;
        n_res       = r_res;
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        o_wr_data   = '0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_rd[AW-1:0];
        o_rnd_start = 1'b0;
        s_keep      = 1'b1;
        s_kept      = i_rd_data;

        unique case (r_state)
            S_INIT: begin
                // one full range after reset
                o_wr_en   = 1'b1;
                o_wr_data = '{start: 32'd0, length: r_region};
                n_len0    = r_region;
                n_state   = S_IDLE;
            end

            S_IDLE: begin
                if (s_cfg_fire) begin
                    n_region  = i_cfg_data;
                    n_live    = CW'(1);
                    n_used    = 32'd0;
                    n_len0    = i_cfg_data;
                    o_wr_en   = 1'b1;
                    o_wr_data = '{start: 32'd0, length: i_cfg_data};
                end
                if (start) begin
                    n_func    = i_func;
                    n_req     = i_req_bytes;
                    n_off     = i_free_offset;
                    n_sz      = i_req_bytes;
                    n_rd      = '0;
                    n_wr      = '0;
                    n_vld     = 1'b0;
                    n_found   = 1'b0;
                    n_boff    = 32'd0;
                    n_granted = 32'd0;
                    if (i_func == FUNC_ALLOC) begin
                        o_rnd_start = 1'b1;
                        n_state     = S_ROUND;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_ROUND: begin
                if (i_rnd_done) begin
                    n_a     = i_rnd_aligned;
                    n_state = S_SCAN;
                    // zero size or overflow: empty pass, table untouched
                    if (!i_rnd_ok) begin
                        n_rd = r_live;
                        n_wr = r_live;
                    end
                end
            end

            S_SCAN: begin
                // issue the next read
                if (r_rd < r_live) begin
                    o_rd_en = 1'b1;
                    n_rd    = r_rd + CW'(1);
                    n_vld   = 1'b1;
                end else begin
                    n_vld = 1'b0;
                end

                // process the entry read last cycle
                if (r_vld) begin
                    if (r_func == FUNC_ALLOC) begin
                        if (!r_found && (i_rd_data.length >= r_a)) begin
                            n_found = 1'b1;
                            n_boff  = i_rd_data.start;
                            if (s_rest < TAIL_LIMIT) begin
                                // small tail absorbed, range removed
                                n_granted = i_rd_data.length;
                                s_keep    = 1'b0;
                            end else begin
                                n_granted = r_a;
                                s_kept    = '{start: i_rd_data.start + r_a, length: s_rest};
                            end
                        end
                    end else begin
                        if (i_rd_data.start == s_end) begin
                            // neighbor above the freed block
                            n_sz   = r_sz + i_rd_data.length;
                            s_keep = 1'b0;
                        end else if (s_eend == r_off) begin
                            // neighbor below the freed block
                            n_off  = r_off - i_rd_data.length;
                            n_sz   = r_sz + i_rd_data.length;
                            s_keep = 1'b0;
                        end
                    end
                    if (s_keep) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_wr[AW-1:0];
                        o_wr_data = s_kept;
                        n_wr      = r_wr + CW'(1);
                        if (r_wr == '0) begin
                            n_len0 = s_kept.length;
                        end
                    end
                end

                // pass complete: commit and report
                if ((r_rd == r_live) && !r_vld) begin
                    n_state            = S_IDLE;
                    n_res_valid        = 1'b1;
                    n_res.block_offset = 32'd0;
                    n_res.granted_bytes = 32'd0;
                    n_res.payload_bytes = 32'd0;
                    if (r_func == FUNC_ALLOC) begin
                        n_live = r_wr;
                        if (r_found) begin
                            n_res.status        = STAT_OK;
                            n_res.block_offset  = r_boff;
                            n_res.granted_bytes = r_granted;
                            n_res.payload_bytes = r_a;
                            n_used              = s_used_add;
                        end else begin
                            n_res.status = STAT_NOFIT;
                        end
                    end else begin
                        if (r_wr < CW'(MAX_RANGES)) begin
                            // append merged range at the end
                            o_wr_en      = 1'b1;
                            o_wr_addr    = r_wr[AW-1:0];
                            o_wr_data    = '{start: r_off, length: r_sz};
                            n_live       = r_wr + CW'(1);
                            n_res.status = STAT_OK;
                            if (r_wr == '0) begin
                                n_len0 = r_sz;
                            end
                        end else begin
                            n_live       = r_wr;
                            n_res.status = STAT_FULL;
                        end
                        n_used = s_used_sub;
                    end
                    n_res.range_count  = 7'(n_live);
                    n_res.region_empty = (n_live == CW'(1)) && (n_len0 == r_region);
                    n_res.used_bytes   = n_used;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_live      <= CW'(1);
            r_rd        <= '0;
            r_wr        <= '0;
            r_vld       <= 1'b0;
            r_found     <= 1'b0;
            r_res_valid <= 1'b0;
            r_used      <= 32'd0;
            r_region    <= REGION_RESET;
            r_len0      <= REGION_RESET;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_vld       <= n_vld;
            r_found     <= n_found;
            r_res_valid <= n_res_valid;
            r_used      <= n_used;
            r_region    <= n_region;
            r_len0      <= n_len0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_req     <= n_req;
        r_off     <= n_off;
        r_sz      <= n_sz;
        r_a       <= n_a;
        r_boff    <= n_boff;
        r_granted <= n_granted;
        r_res     <= n_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### hw/rtl/first_fit_range_allocator_top.sv
`timescale 1ns / 1ps
// First-fit range allocator, top level: sequencer, rounding unit, range memory.
// Depends on ffra_pkg, ffra_ctrl, ffra_round and ffra_mem.

// Requests are taken while busy is low and each produces exactly one result,
// shown for a single cycle on o_res_valid; the receiver cannot stall it, so it
// must take every result when it appears. Every request but a zero-size or
// overflowing allocate streams the live free ranges through the single read
// port of the range memory, one entry per cycle, compacting the table as it
// goes. An allocate first rounds its size to the line size (a three-stage
// reciprocal multiply) before its pass. After reset the block writes the
// initial full range in its init state before it raises ready; no clearing
// pass is needed since entries past the live count are never read. Writing
// the region size on i_cfg_data rebuilds the table to one full range in the
// cycle of the write.
module first_fit_range_allocator_top #(
    parameter int MAX_RANGES = ffra_pkg::MAX_RANGES_DEF,
    parameter int LINE_BYTES = ffra_pkg::LINE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [31:0] i_req_bytes,
    input  logic [31:0] i_free_offset,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // result
    output logic        o_res_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_block_offset,
    output logic [31:0] o_granted_bytes,
    output logic [31:0] o_payload_bytes,
    output logic [6:0]  o_range_count,
    output logic        o_region_empty,
    output logic [31:0] o_used_bytes
);
    import ffra_pkg::*;

    localparam int AW = $clog2(MAX_RANGES);

    logic          rnd_start;
    logic          rnd_done;
    logic [31:0]   rnd_aligned;
    logic          rnd_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_range        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_range        rd_data;
    t_result       res;

    ffra_ctrl #(
        .MAX_RANGES (MAX_RANGES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_req_bytes   (i_req_bytes),
        .i_free_offset (i_free_offset),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_rnd_start   (rnd_start),
        .i_rnd_done    (rnd_done),
        .i_rnd_aligned (rnd_aligned),
        .i_rnd_ok      (rnd_ok),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_res_valid   (o_res_valid),
        .o_res         (res)
    );

    ffra_round #(
        .LINE_BYTES (LINE_BYTES)
    ) u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rnd_start),
        .i_value   (i_req_bytes),
        .o_done    (rnd_done),
        .o_aligned (rnd_aligned),
        .o_ok      (rnd_ok)
    );

    ffra_mem #(
        .DEPTH (MAX_RANGES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Result fields
    assign o_status        = res.status;
    assign o_block_offset  = res.block_offset;
    assign o_granted_bytes = res.granted_bytes;
    assign o_payload_bytes = res.payload_bytes;
    assign o_range_count   = res.range_count;
    assign o_region_empty  = res.region_empty;
    assign o_used_bytes    = res.used_bytes;

endmodule

### hw/rtl/ffra_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the range allocator, bound to the top level.
// Depends on ffra_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_res_valid,
    input logic [1:0]  o_status,
    input logic [31:0] o_block_offset,
    input logic [31:0] o_granted_bytes,
    input logic [6:0]  o_range_count,
    input logic        o_region_empty
);
    import ffra_pkg::*;

    // An accepted request keeps the block busy until its result
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // The result transaction comes as the block returns to idle
    `ASSERT_IMPLY(a_res_idle, i_clk, i_rst_n, o_res_valid, !busy)

    // One result per request: never two strobes back to back
    `ASSERT_NEXT(a_res_single, i_clk, i_rst_n, o_res_valid, !o_res_valid)

    // Any result with a status other than OK reports no block
    `ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, o_res_valid && (o_status != STAT_OK),
        (o_block_offset == 32'd0) && (o_granted_bytes == 32'd0))

    // An empty region is one single range
    `ASSERT_IMPLY(a_empty_one, i_clk, i_rst_n, o_res_valid && o_region_empty,
        o_range_count == 7'd1)

endmodule

bind first_fit_range_allocator_top ffra_checker u_ffra_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_res_valid     (o_res_valid),
    .o_status        (o_status),
    .o_block_offset  (o_block_offset),
    .o_granted_bytes (o_granted_bytes),
    .o_range_count   (o_range_count),
    .o_region_empty  (o_region_empty)
);

### tb/sv/first_fit_range_allocator_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_range_allocator_top: directed table, then
// fragmentation and mixed allocate/free phases over several region sizes.
// Depends on ffra_pkg and the allocator RTL; results are checked by an in-bench model.
module first_fit_range_allocator_top_test;
    import ffra_pkg::*;

    localparam int MAX_RANGES  = MAX_RANGES_DEF;
    localparam int LINE_BYTES  = LINE_BYTES_DEF;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int SETTLE      = 100;
    localparam int FRAG_BLOCKS = 130;

    // Kinds of directed rows
    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_TYPED,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        fn;
        logic [31:0] req;
        logic [31:0] off;
        t_result     res;
    } t_dir_row;

    localparam int N_DIRECTED = 23;

    // Directed rows; typed results only where they are obvious, the rest predicted.
    // For configuration rows req carries the region size.
    t_dir_row directed_rows [N_DIRECTED] = '{
        // zero size and two rounding overflows, each no fit, from reset
        '{ROW_TYPED, FUNC_ALLOC, 32'h0000_0000, 32'h0000_0000,
          '{STAT_NOFIT, 32'd0, 32'd0, 32'd0, 7'd1, 1'b1, 32'd0}},
        '{ROW_TYPED, FUNC_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          '{STAT_NOFIT, 32'd0, 32'd0, 32'd0, 7'd1, 1'b1, 32'd0}},
        '{ROW_TYPED, FUNC_ALLOC, 32'hFFFF_FFC1, 32'h0000_0000,
          '{STAT_NOFIT, 32'd0, 32'd0, 32'd0, 7'd1, 1'b1, 32'd0}},
        // smallest allocate rounds up to one line
        '{ROW_TYPED, FUNC_ALLOC, 32'h0000_0001, 32'h0000_0000,
          '{STAT_OK, 32'd0, 32'd64, 32'd64, 7'd1, 1'b0, 32'd64}},
        '{ROW_PRED,  FUNC_ALLOC, 32'd100,       32'h5555_5555, '0},
        // free appends, then a free that merges on both sides
        '{ROW_PRED,  FUNC_FREE,  32'd64,        32'd0,         '0},
        '{ROW_PRED,  FUNC_FREE,  32'd128,       32'd64,        '0},
        // small leftover tail is absorbed, table goes empty
        '{ROW_PRED,  FUNC_ALLOC, 32'h03FF_F001, 32'hAAAA_AAAA, '0},
        '{ROW_PRED,  FUNC_ALLOC, 32'd64,        32'd0,         '0},
        '{ROW_PRED,  FUNC_FREE,  32'h03FF_F040, 32'd0,         '0},
        // wrapping end address, zero-size frees
        '{ROW_PRED,  FUNC_FREE,  32'h0000_0040, 32'hFFFF_FFC0, '0},
        '{ROW_PRED,  FUNC_FREE,  32'h0000_0000, 32'h1234_5678, '0},
        '{ROW_PRED,  FUNC_FREE,  32'h0000_0000, 32'h03FF_F040, '0},
        '{ROW_PRED,  FUNC_ALLOC, 32'h8000_0000, 32'd0,         '0},
        // usage floor on an oversized free
        '{ROW_PRED,  FUNC_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, '0},
        '{ROW_PRED,  FUNC_ALLOC, 32'hFFFF_FFC0, 32'd0,         '0},
        // largest region, double free, usage ceiling
        '{ROW_CFG,   FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0,         '0},
        '{ROW_TYPED, FUNC_ALLOC, 32'h8000_0000, 32'd0,
          '{STAT_OK, 32'd0, 32'h8000_0000, 32'h8000_0000, 7'd1, 1'b0, 32'h8000_0000}},
        '{ROW_TYPED, FUNC_FREE,  32'h8000_0000, 32'd0,
          '{STAT_OK, 32'd0, 32'd0, 32'd0, 7'd1, 1'b1, 32'd0}},
        '{ROW_PRED,  FUNC_FREE,  32'h8000_0000, 32'd0,         '0},
        '{ROW_PRED,  FUNC_ALLOC, 32'hFFFF_FFC0, 32'd0,         '0},
        '{ROW_PRED,  FUNC_ALLOC, 32'h8000_0000, 32'd0,         '0},
        '{ROW_PRED,  FUNC_FREE,  32'hFFFF_FFFF, 32'h1234_5678, '0}
    };

    // DUT signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_func = FUNC_ALLOC;
    logic [31:0] i_req_bytes = '0;
    logic [31:0] i_free_offset = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        o_res_valid;
    logic [1:0]  o_status;
    logic [31:0] o_block_offset;
    logic [31:0] o_granted_bytes;
    logic [31:0] o_payload_bytes;
    logic [6:0]  o_range_count;
    logic        o_region_empty;
    logic [31:0] o_used_bytes;

    // Model state of the free range table
    logic [31:0] free_base [MAX_RANGES];
    logic [31:0] free_size [MAX_RANGES];
    int          n_ranges;
    logic [31:0] bytes_used;
    logic [31:0] region_size;

    // Responses still owed by the block, oldest first
    t_result     alloc_replies_due [$];

    // Blocks handed out and not yet freed, for well-formed frees
    logic [31:0] live_offs [$];
    logic [31:0] live_sizes [$];

    // Idle control and bookkeeping
    bit          idle_allowed = 1'b1;
    bit          idle_quiet = 1'b0;
    int          mismatches = 0;
    int          n_checked = 0;
    int          n_alloc = 0;
    int          n_free = 0;
    int          n_full = 0;
    int          n_absorb = 0;
    int          n_nofit = 0;
    int          n_cfg = 0;
    int          cycle_count = 0;

    first_fit_range_allocator_top #(
        .MAX_RANGES (MAX_RANGES),
        .LINE_BYTES (LINE_BYTES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_req_bytes     (i_req_bytes),
        .i_free_offset   (i_free_offset),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_res_valid     (o_res_valid),
        .o_status        (o_status),
        .o_block_offset  (o_block_offset),
        .o_granted_bytes (o_granted_bytes),
        .o_payload_bytes (o_payload_bytes),
        .o_range_count   (o_range_count),
        .o_region_empty  (o_region_empty),
        .o_used_bytes    (o_used_bytes)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Table rebuild: one range over the whole region, nothing in use
    function automatic void rebuild_table(input logic [31:0] region);
        region_size = region;
        for (int k = 0; k < MAX_RANGES; k++) begin
            free_base[k] = '0;
            free_size[k] = '0;
        end
        free_size[0] = region;
        n_ranges     = 1;
        bytes_used   = '0;
        live_offs.delete();
        live_sizes.delete();
    endfunction

    // Close the gap left by a removed range
    function automatic void remove_range(input int idx);
        for (int k = idx; k + 1 < n_ranges; k++) begin
            free_base[k] = free_base[k + 1];
            free_size[k] = free_size[k + 1];
        end
        if (n_ranges > 0) n_ranges--;
    endfunction

    // First-fit allocate / coalescing free on the model table
    function automatic t_result apply_range_op(input logic fn, input logic [31:0] req,
                                               input logic [31:0] off);
        t_result           r;
        longint unsigned   rounded;
        logic [31:0]       a;
        logic [31:0]       cur_off;
        logic [31:0]       cur_sz;
        logic [31:0]       blk_end;
        logic [31:0]       rng_end;
        int                i;
        r = '0;
        if (fn == FUNC_ALLOC) begin
            n_alloc++;
            rounded  = {32'd0, req};
            rounded  = (rounded + LINE_BYTES - 1) / LINE_BYTES * LINE_BYTES;
            r.status = STAT_NOFIT;
            if (req != 0 && rounded <= 64'hFFFF_FFFF) begin
                a = rounded[31:0];
                for (i = 0; i < n_ranges; i++) begin
                    if (free_size[i] >= a) begin
                        r.status        = STAT_OK;
                        r.block_offset  = free_base[i];
                        r.granted_bytes = a;
                        r.payload_bytes = a;
                        free_base[i]    = free_base[i] + a;
                        free_size[i]    = free_size[i] - a;
                        // short leftover goes with the block
                        if (free_size[i] < TAIL_LIMIT) begin
                            r.granted_bytes = a + free_size[i];
                            remove_range(i);
                            n_absorb++;
                        end
                        bytes_used = (bytes_used > 32'hFFFF_FFFF - a) ? 32'hFFFF_FFFF
                                                                     : bytes_used + a;
                        break;
                    end
                end
            end
            if (r.status == STAT_NOFIT) n_nofit++;
        end else begin
            n_free++;
            cur_off = off;
            cur_sz  = req;
            i = 0;
            // single pass, merging neighbors on either side
            while (i < n_ranges) begin
                blk_end = cur_off + cur_sz;
                rng_end = free_base[i] + free_size[i];
                if (free_base[i] == blk_end) begin
                    cur_sz = cur_sz + free_size[i];
                    remove_range(i);
                end else if (rng_end == cur_off) begin
                    cur_off = cur_off - free_size[i];
                    cur_sz  = cur_sz + free_size[i];
                    remove_range(i);
                end else begin
                    i++;
                end
            end
            if (n_ranges < MAX_RANGES) begin
                free_base[n_ranges] = cur_off;
                free_size[n_ranges] = cur_sz;
                n_ranges++;
            end else begin
                r.status = STAT_FULL;
                n_full++;
            end
            bytes_used = (bytes_used < req) ? 32'd0 : bytes_used - req;
        end
        r.range_count  = 7'(n_ranges);
        r.region_empty = (n_ranges == 1 && free_size[0] == region_size);
        r.used_bytes   = bytes_used;
        return r;
    endfunction

    // Random idle bursts before requests, with quiet stretches in between
    function automatic int pick_gap();
        if (!idle_allowed) return 0;
        if ($urandom_range(0, 15) == 0) idle_quiet = !idle_quiet;
        if (idle_quiet || $urandom_range(0, 2) != 0) return 0;
        return $urandom_range(1, 5);
    endfunction

    // Drive one request, wait until busy is low again, queue the expected response
    task automatic issue_request(input logic fn, input logic [31:0] req,
                                 input logic [31:0] off, input bit typed,
                                 input t_result typed_res, output t_result reply);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_func        <= fn;
        i_req_bytes   <= req;
        i_free_offset <= off;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        reply = apply_range_op(fn, req, off);
        alloc_replies_due = {alloc_replies_due, (typed ? typed_res : reply)};
    endtask

    // Region write, only once all owed responses are in
    task automatic write_region(input logic [31:0] region);
        start <= 1'b0;
        while (alloc_replies_due.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= region;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        rebuild_table(region);
        n_cfg++;
    endtask

    // Allocate size: mostly small, some medium, rare region-scale or arbitrary
    function automatic logic [31:0] pick_alloc_size();
        int          c;
        logic [31:0] cap;
        c   = $urandom_range(0, 99);
        cap = (region_size >> 2) == 0 ? 32'd1 : region_size >> 2;
        if (c < 65) return $urandom_range(1, 4096);
        if (c < 88) return $urandom_range(1, 65536);
        if (c < 98) return $urandom_range(1, cap);
        return $urandom;
    endfunction

    // Mixed traffic: mostly allocates and real frees, some noise
    task automatic run_mixed_phase(input logic [31:0] region, input int count);
        t_result     reply;
        int          roll;
        int          idx;
        logic        fn;
        logic [31:0] req;
        logic [31:0] off;
        write_region(region);
        repeat (count) begin
            roll = $urandom_range(0, 99);
            off  = $urandom;
            if (roll < 40 || (roll < 85 && live_offs.size() == 0)) begin
                fn  = FUNC_ALLOC;
                req = pick_alloc_size();
            end else if (roll < 85) begin
                idx = $urandom_range(0, live_offs.size() - 1);
                fn  = FUNC_FREE;
                req = live_sizes[idx];
                off = live_offs[idx];
                live_offs.delete(idx);
                live_sizes.delete(idx);
            end else if (roll < 92) begin
                // bogus free, unchecked by the block
                fn  = FUNC_FREE;
                req = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8192);
            end else if (roll < 96) begin
                fn  = FUNC_ALLOC;
                req = '0;
            end else begin
                fn  = FUNC_ALLOC;
                req = $urandom | 32'h8000_0000;
            end
            issue_request(fn, req, off, 1'b0, '0, reply);
            if (fn == FUNC_ALLOC && reply.status == STAT_OK) begin
                live_offs  = {live_offs, reply.block_offset};
                live_sizes = {live_sizes, reply.payload_bytes};
            end
        end
    endtask

    // Checkerboard of one-line blocks: fills the range table past full, then
    // frees the rest in random order so they coalesce back
    task automatic run_fragment_phase();
        t_result     reply;
        logic [31:0] blk [FRAG_BLOCKS];
        int          order [$];
        int          m;
        int          t;
        write_region(32'h0010_0000);
        for (int k = 0; k < FRAG_BLOCKS; k++) begin
            issue_request(FUNC_ALLOC, $urandom_range(1, LINE_BYTES), $urandom, 1'b0, '0,
                          reply);
            blk[k] = reply.block_offset;
        end
        for (int k = 0; k < FRAG_BLOCKS; k += 2)
            issue_request(FUNC_FREE, LINE_BYTES, blk[k], 1'b0, '0, reply);
        for (int k = 1; k < FRAG_BLOCKS; k += 2) order = {order, k};
        for (int j = order.size() - 1; j > 0; j--) begin
            m        = $urandom_range(0, j);
            t        = order[j];
            order[j] = order[m];
            order[m] = t;
        end
        foreach (order[j])
            issue_request(FUNC_FREE, LINE_BYTES, blk[order[j]], 1'b0, '0, reply);
    endtask

    // Response checker: every strobe is matched against the oldest owed response
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        bit      bad;
        if (i_rst_n && o_res_valid) begin
            got.status        = o_status;
            got.block_offset  = o_block_offset;
            got.granted_bytes = o_granted_bytes;
            got.payload_bytes = o_payload_bytes;
            got.range_count   = o_range_count;
            got.region_empty  = o_region_empty;
            got.used_bytes    = o_used_bytes;
            if (alloc_replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("extra: st=%0d off=%h gr=%h pl=%h cnt=%0d emp=%0d used=%h",
                             got.status, got.block_offset, got.granted_bytes,
                             got.payload_bytes, got.range_count, got.region_empty,
                             got.used_bytes);
            end else begin
                want = alloc_replies_due.pop_front();
                n_checked++;
                bad = (got.status        !== want.status)        ||
                      (got.block_offset  !== want.block_offset)  ||
                      (got.granted_bytes !== want.granted_bytes) ||
                      (got.payload_bytes !== want.payload_bytes) ||
                      (got.range_count   !== want.range_count)   ||
                      (got.region_empty  !== want.region_empty)  ||
                      (got.used_bytes    !== want.used_bytes);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on transaction %0d", n_checked);
                        $display("  exp: st=%0d off=%h gr=%h pl=%h cnt=%0d emp=%0d used=%h",
                                 want.status, want.block_offset, want.granted_bytes,
                                 want.payload_bytes, want.range_count, want.region_empty,
                                 want.used_bytes);
                        $display("  got: st=%0d off=%h gr=%h pl=%h cnt=%0d emp=%0d used=%h",
                                 got.status, got.block_offset, got.granted_bytes,
                                 got.payload_bytes, got.range_count, got.region_empty,
                                 got.used_bytes);
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus sequence
    initial begin
        t_result reply;
        rebuild_table(REGION_RESET);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].kind == ROW_CFG)
                write_region(directed_rows[r].req);
            else
                issue_request(directed_rows[r].fn, directed_rows[r].req,
                              directed_rows[r].off, directed_rows[r].kind == ROW_TYPED,
                              directed_rows[r].res, reply);
        end

        // table overflow and coalescing, then mixed traffic over several regions
        run_fragment_phase();
        run_mixed_phase(REGION_RESET, 30);
        run_mixed_phase(32'd4096, 20);
        run_mixed_phase(32'hFFFF_FFFF, 30);
        run_mixed_phase($urandom_range(32'h0001_0000, 32'hFFFF_FFFF), 20);
        idle_allowed = 1'b0;
        run_mixed_phase($urandom_range(4096, 32'h0010_0000), 30);

        // drain
        start <= 1'b0;
        while (alloc_replies_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        mismatches += alloc_replies_due.size();

        $display("Ran %0d requests (%0d allocate, %0d free) across %0d region writes.",
                 n_alloc + n_free, n_alloc, n_free, n_cfg);
        $display("Checked %0d responses: %0d table full, %0d tail absorbs, %0d no fit.",
                 n_checked, n_full, n_absorb, n_nofit);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_round.sv
hw/rtl/ffra_mem.sv
hw/rtl/ffra_ctrl.sv
hw/rtl/first_fit_range_allocator_top.sv
hw/rtl/ffra_checker.sv
tb/sv/first_fit_range_allocator_top_test.sv
